### rtl/core/btnrep_pkg.sv
`default_nettype none

package btnrep_pkg;

    // Field and register widths.
    localparam int unsigned BTN_W   = 4;
    localparam int unsigned MS_W    = 12;
    localparam int unsigned DEB_W   = 11;
    localparam int unsigned STEP_W  = 16;
    localparam int unsigned FREQ_W  = 17;
    localparam int unsigned AMP_W   = 11;
    localparam int unsigned WAVE_W  = 2;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_REPEAT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_REPEAT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_UP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_DOWN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_HIGH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_LOW     = 3'd6;

    // Register reset values.
    localparam logic [DEB_W-1:0]  RST_DEBOUNCE     = 11'd20;
    localparam logic [MS_W-1:0]   RST_FIRST_REPEAT = 12'd1000;
    localparam logic [MS_W-1:0]   RST_FAST_REPEAT  = 12'd200;
    localparam logic [STEP_W-1:0] RST_FREQ_UP      = 16'd50;
    localparam logic [STEP_W-1:0] RST_FREQ_DOWN    = 16'd50;
    localparam logic [FREQ_W-1:0] RST_FREQ_HIGH    = 17'd100000;
    localparam logic [FREQ_W-1:0] RST_FREQ_LOW     = 17'd5;
    localparam logic [FREQ_W-1:0] RST_FREQ_VALUE   = 17'd1000;

    // Button patterns (active low).
    localparam logic [BTN_W-1:0] PAT_RELEASED = 4'b1111;
    localparam logic [BTN_W-1:0] PAT_AMP_UP   = 4'b0101;
    localparam logic [BTN_W-1:0] PAT_AMP_DOWN = 4'b0110;
    localparam logic [BTN_W-1:0] PAT_FREQ_UP  = 4'b1001;
    localparam logic [BTN_W-1:0] PAT_FREQ_DN  = 4'b1010;
    localparam logic [BTN_W-1:0] PAT_WAVE     = 4'b1101;

    // Limits.
    localparam logic [MS_W-1:0]   MS_MAX        = 12'hFFF;
    localparam logic [FREQ_W-1:0] FREQ_MAX      = 17'h1FFFF;
    localparam logic [CNT_W-1:0]  COUNT_MAX     = 3'd7;
    localparam logic [CNT_W-1:0]  FAST_AFTER    = 3'd4;
    localparam logic [WAVE_W-1:0] WAVE_LAST     = 2'd2;

    typedef enum logic [3:0] {
        PH_POLL    = 4'b0001,
        PH_DEB     = 4'b0010,
        PH_DECODE  = 4'b0100,
        PH_RELEASE = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ms;
        logic [MS_W-1:0]   first_repeat_ms;
        logic [MS_W-1:0]   fast_repeat_ms;
        logic [STEP_W-1:0] freq_up_step;
        logic [STEP_W-1:0] freq_down_step;
        logic [FREQ_W-1:0] freq_limit_high;
        logic [FREQ_W-1:0] freq_limit_low;
    } cfg_t;

    typedef struct packed {
        logic [AMP_W-1:0]  amplitude;
        logic [FREQ_W-1:0] frequency;
        logic [WAVE_W-1:0] waveform;
        logic              changed;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/btnrep_cfg_regs.sv
`default_nettype none

module btnrep_cfg_regs (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_we,
    input  wire  [btnrep_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [btnrep_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output btnrep_pkg::cfg_t                      cfg
);

    btnrep_pkg::cfg_t cfg_reg;
    btnrep_pkg::cfg_t cfg_next;

    // Decode the write; each register keeps only its own low bits.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                btnrep_pkg::REG_DEBOUNCE:
                    cfg_next.debounce_ms = cfg_wdata[btnrep_pkg::DEB_W-1:0];
                btnrep_pkg::REG_FIRST_REPEAT:
                    cfg_next.first_repeat_ms = cfg_wdata[btnrep_pkg::MS_W-1:0];
                btnrep_pkg::REG_FAST_REPEAT:
                    cfg_next.fast_repeat_ms = cfg_wdata[btnrep_pkg::MS_W-1:0];
                btnrep_pkg::REG_FREQ_UP:
                    cfg_next.freq_up_step = cfg_wdata[btnrep_pkg::STEP_W-1:0];
                btnrep_pkg::REG_FREQ_DOWN:
                    cfg_next.freq_down_step = cfg_wdata[btnrep_pkg::STEP_W-1:0];
                btnrep_pkg::REG_FREQ_HIGH:
                    cfg_next.freq_limit_high = cfg_wdata[btnrep_pkg::FREQ_W-1:0];
                btnrep_pkg::REG_FREQ_LOW:
                    cfg_next.freq_limit_low = cfg_wdata[btnrep_pkg::FREQ_W-1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms     <= btnrep_pkg::RST_DEBOUNCE;
            cfg_reg.first_repeat_ms <= btnrep_pkg::RST_FIRST_REPEAT;
            cfg_reg.fast_repeat_ms  <= btnrep_pkg::RST_FAST_REPEAT;
            cfg_reg.freq_up_step    <= btnrep_pkg::RST_FREQ_UP;
            cfg_reg.freq_down_step  <= btnrep_pkg::RST_FREQ_DOWN;
            cfg_reg.freq_limit_high <= btnrep_pkg::RST_FREQ_HIGH;
            cfg_reg.freq_limit_low  <= btnrep_pkg::RST_FREQ_LOW;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/core/btnrep_core.sv
`default_nettype none

module btnrep_core #(
    parameter int unsigned AMP_LEVELS = 128
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               step_en,
    input  wire  [btnrep_pkg::BTN_W-1:0]      buttons,
    input  wire                               ms_tick,
    input  wire  btnrep_pkg::cfg_t            cfg,
    output btnrep_pkg::result_t               result
);

    localparam logic [btnrep_pkg::AMP_W-1:0] AMP_TOP = btnrep_pkg::AMP_W'(AMP_LEVELS);

    btnrep_pkg::phase_t                 phase_reg, phase_next;
    logic [btnrep_pkg::BTN_W-1:0]       held_reg, held_next;
    logic [btnrep_pkg::MS_W-1:0]        elapsed_reg, elapsed_next, elapsed_tick;
    logic [btnrep_pkg::MS_W-1:0]        delay_reg, delay_next;
    logic [btnrep_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [btnrep_pkg::AMP_W-1:0]       amp_reg, amp_next;
    logic [btnrep_pkg::FREQ_W-1:0]      freq_reg, freq_next;
    logic [btnrep_pkg::WAVE_W-1:0]      wave_reg, wave_next;
    logic                               changed;
    logic [btnrep_pkg::FREQ_W:0]        freq_sum;

    // Millisecond counter advances first and saturates.
    assign elapsed_tick = (ms_tick && (elapsed_reg != btnrep_pkg::MS_MAX))
                          ? elapsed_reg + 1'b1 : elapsed_reg;

    assign freq_sum = {1'b0, freq_reg} + {2'b00, cfg.freq_up_step};

    // One poll step: phase sequencing and command decode.
    always_comb begin
        phase_next   = phase_reg;
        held_next    = held_reg;
        elapsed_next = elapsed_tick;
        delay_next   = delay_reg;
        count_next   = count_reg;
        amp_next     = amp_reg;
        freq_next    = freq_reg;
        wave_next    = wave_reg;
        changed      = 1'b0;
        case (phase_reg)
            btnrep_pkg::PH_POLL: begin
                held_next = buttons;
                if (buttons != btnrep_pkg::PAT_RELEASED) begin
                    phase_next   = btnrep_pkg::PH_DEB;
                    elapsed_next = '0;
                end
            end
            btnrep_pkg::PH_DEB: begin
                if (elapsed_tick >= {1'b0, cfg.debounce_ms}) begin
                    phase_next = (buttons == held_reg) ? btnrep_pkg::PH_DECODE
                                                       : btnrep_pkg::PH_POLL;
                    delay_next = cfg.first_repeat_ms;
                    count_next = '0;
                end
            end
            btnrep_pkg::PH_DECODE: begin
                elapsed_next = '0;
                changed      = 1'b1;
                case (held_reg)
                    btnrep_pkg::PAT_AMP_UP: begin
                        if (amp_reg < AMP_TOP) amp_next = amp_reg + 1'b1;
                    end
                    btnrep_pkg::PAT_AMP_DOWN: begin
                        if (amp_reg != '0) amp_next = amp_reg - 1'b1;
                    end
                    btnrep_pkg::PAT_FREQ_UP: begin
                        if (freq_reg < cfg.freq_limit_high) begin
                            freq_next = freq_sum[btnrep_pkg::FREQ_W]
                                        ? btnrep_pkg::FREQ_MAX
                                        : freq_sum[btnrep_pkg::FREQ_W-1:0];
                        end
                    end
                    btnrep_pkg::PAT_FREQ_DN: begin
                        if (freq_reg > cfg.freq_limit_low) begin
                            freq_next = (freq_reg >= {1'b0, cfg.freq_down_step})
                                        ? freq_reg - {1'b0, cfg.freq_down_step}
                                        : '0;
                        end
                    end
                    btnrep_pkg::PAT_WAVE: begin
                        wave_next = (wave_reg >= btnrep_pkg::WAVE_LAST)
                                    ? '0 : wave_reg + 1'b1;
                    end
                    default: begin
                        changed = 1'b0;
                    end
                endcase
                phase_next = changed ? btnrep_pkg::PH_RELEASE : btnrep_pkg::PH_POLL;
            end
            btnrep_pkg::PH_RELEASE: begin
                if (buttons != held_reg) begin
                    phase_next = btnrep_pkg::PH_POLL;
                end else if (elapsed_tick >= delay_reg) begin
                    phase_next = btnrep_pkg::PH_DECODE;
                    if (count_reg > btnrep_pkg::FAST_AFTER) delay_next = cfg.fast_repeat_ms;
                    if (count_reg != btnrep_pkg::COUNT_MAX) count_next = count_reg + 1'b1;
                end
            end
            default: begin
                phase_next = btnrep_pkg::PH_POLL;
            end
        endcase
    end

    // Control state and settings update once per accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= btnrep_pkg::PH_POLL;
            held_reg    <= '0;
            elapsed_reg <= '0;
            delay_reg   <= btnrep_pkg::RST_FIRST_REPEAT;
            count_reg   <= '0;
            amp_reg     <= '0;
            freq_reg    <= btnrep_pkg::RST_FREQ_VALUE;
            wave_reg    <= '0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            held_reg    <= held_next;
            elapsed_reg <= elapsed_next;
            delay_reg   <= delay_next;
            count_reg   <= count_next;
            amp_reg     <= amp_next;
            freq_reg    <= freq_next;
            wave_reg    <= wave_next;
        end
    end

    // The result shows the settings after this step.
    assign result.amplitude = amp_next;
    assign result.frequency = freq_next;
    assign result.waveform  = wave_next;
    assign result.changed   = changed;

endmodule

`default_nettype wire

### rtl/core/button_setting_control_autorepeat.sv
`default_nettype none
// Channel   Direction  Handshake           Word
// s_        in         s_valid / s_ready   s_buttons, s_ms_tick
// m_        out        m_valid / m_ready   m_amplitude, m_frequency, m_waveform, m_changed
// cfg_      in         cfg_we              cfg_index, cfg_wdata (no read-back)
//
// One word per cycle sustained while the result is not stalled; each word passes through the
// input register, then the single-step update into the result register.
// Synchronous active-low reset restores the register defaults and settings.
// A stalled result holds the pipe; s_ready falls only when both registers are full
// and m_ready is low.

module button_setting_control_autorepeat #(
    parameter int unsigned AMP_LEVELS = 128
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [btnrep_pkg::BTN_W-1:0]         s_buttons,
    input  wire                                  s_ms_tick,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [btnrep_pkg::AMP_W-1:0]         m_amplitude,
    output logic [btnrep_pkg::FREQ_W-1:0]        m_frequency,
    output logic [btnrep_pkg::WAVE_W-1:0]        m_waveform,
    output logic                                 m_changed,
    input  wire                                  cfg_we,
    input  wire  [btnrep_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [btnrep_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    btnrep_pkg::cfg_t              cfg;
    btnrep_pkg::result_t           result;
    logic                          in_valid_reg;
    logic [btnrep_pkg::BTN_W-1:0]  in_buttons_reg;
    logic                          in_tick_reg;
    logic                          out_valid_reg;
    btnrep_pkg::result_t           out_reg;
    logic                          advance;

    // The input word moves on whenever the result register is free.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    btnrep_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    btnrep_core #(
        .AMP_LEVELS (AMP_LEVELS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (in_valid_reg && advance),
        .buttons (in_buttons_reg),
        .ms_tick (in_tick_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_buttons_reg <= s_buttons;
            in_tick_reg    <= s_ms_tick;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_reg <= result;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_amplitude = out_reg.amplitude;
    assign m_frequency = out_reg.frequency;
    assign m_waveform  = out_reg.waveform;
    assign m_changed   = out_reg.changed;

endmodule

`default_nettype wire
